// ----- design/msd_pkg.sv -----
// Shared types and constants for the MPEG audio stream detector.
// Used by msd_ctrl, msd_datapath, the core top level and the checker.
package msd_pkg;

    // Offsets at or above this are never checked for a frame header
    localparam int SCAN_LIMIT    = 65536;
    // Mismatching headers tolerated before a "no" verdict
    localparam int COMPARE_LIMIT = 10;
    // Byte count saturates here
    localparam int POS_CAP       = SCAN_LIMIT + 4;
    localparam int POS_W         = $clog2(POS_CAP + 1);

    localparam int CNT_W         = 4;
    localparam int TAG_W         = 29;
    localparam int SKIP_W        = 29;

    // Stored file prefix (ID3v2 header length)
    localparam int PREFIX_LEN    = 10;
    localparam int PIDX_W        = $clog2(PREFIX_LEN);
    // Replay covers offsets 0..5 at most
    localparam int RP_W          = 3;
    localparam int RP_MAX_OFF    = 5;

    // Bytes skipped after a valid header (on top of the current offset)
    localparam int HDR_SKIP      = 3;
    // ID3v2 header and footer each add this many bytes
    localparam int ID3_HDR_LEN   = 10;
    // Byte count from which the window is checked in stream (offset 6 onward)
    localparam int STREAM_START  = 10;
    // Skip already consumed by offsets 0..5 at the tenth byte
    localparam int TAG_PRE_OFF   = 6;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [SKIP_W-1:0] skip_t;
    typedef logic [TAG_W-1:0]  tag_t;

    typedef enum logic [1:0] {
        VD_NONE = 2'd0,
        VD_YES  = 2'd1,
        VD_NO   = 2'd2
    } verdict_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic take;         // scan the accepted word
        logic replay_step;  // check the oldest stored prefix offset
        logic emit;         // load the result register
        logic clear_file;   // end of file: reset per-file state
        logic set_decided;  // verdict reached, ignore rest of file
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic     decided;
        logic     pos_is9;    // tenth byte of the file
        logic     pos_short;  // byte 5..9 of the file (count 4..8)
        logic     tag_found;  // ID3v2 tag present at the tenth byte
        logic     rp_done;    // current replay step is the final one
        logic     out_full;
        verdict_t verdict;
    } stat_t;

endpackage

// ----- design/msd_ctrl.sv -----
// Controller for the MPEG audio stream detector: byte handshake,
// prefix replay sequencing and verdict emission. Uses msd_pkg.
module msd_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    output logic             byte_ready,
    input  logic             last_byte,
    input  logic             result_ready,
    input  msd_pkg::stat_t   stat,
    output msd_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_RUN    = 2'b01,
        ST_REPLAY = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   last_reg, last_next;
    logic   acc;

    // Take a word when running and the result slot is free or draining
    assign byte_ready = (state_reg == ST_RUN) && (!stat.out_full || result_ready);
    assign acc        = byte_valid && byte_ready;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        case (state_reg)
            ST_RUN:
            begin
                if (acc)
                begin
                    if (stat.decided)
                    begin
                        cmd.clear_file = last_byte;
                    end
                    else
                    begin
                        cmd.take = 1'b1;
                        if ((stat.pos_is9 && !stat.tag_found) ||
                            (last_byte && stat.pos_short))
                        begin
                            state_next = ST_REPLAY;
                            last_next  = last_byte;
                        end
                        else if ((stat.verdict != msd_pkg::VD_NONE) || last_byte)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.clear_file  = last_byte;
                            cmd.set_decided = !last_byte;
                        end
                    end
                end
            end
            ST_REPLAY:
            begin
                cmd.replay_step = 1'b1;
                if ((stat.verdict != msd_pkg::VD_NONE) || stat.rp_done)
                begin
                    state_next = ST_RUN;
                    if ((stat.verdict != msd_pkg::VD_NONE) || last_reg)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.clear_file  = last_reg;
                        cmd.set_decided = !last_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

endmodule

// ----- design/msd_datapath.sv -----
// Datapath for the MPEG audio stream detector: prefix store, byte window,
// header check unit, per-file counters and the result register. Uses msd_pkg.
module msd_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  msd_pkg::cmd_t               cmd,
    input  logic [7:0]                  data_byte,
    input  logic                        result_ready,
    output msd_pkg::stat_t              stat,
    output logic                        result_valid,
    output logic                        is_mp3,
    output logic [msd_pkg::TAG_W-1:0]   tag_length
);

    localparam msd_pkg::pos_t POS_4    = msd_pkg::POS_W'(4);
    localparam msd_pkg::pos_t POS_8    = msd_pkg::POS_W'(8);
    localparam msd_pkg::pos_t POS_9    = msd_pkg::POS_W'(9);
    localparam msd_pkg::pos_t POS_STRM = msd_pkg::POS_W'(msd_pkg::STREAM_START);
    localparam msd_pkg::pos_t POS_PRE  = msd_pkg::POS_W'(msd_pkg::PREFIX_LEN);
    localparam msd_pkg::pos_t POS_MAX  = msd_pkg::POS_W'(msd_pkg::POS_CAP);

    // Frame header validity on its first three bytes
    function automatic logic hdr_ok(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2);
        hdr_ok = (b0 == 8'hFF) &&
                 (((b1 & 8'hF0) == 8'hF0) || ((b1 & 8'hFE) == 8'hE2)) &&
                 (b1[2:1] != 2'd0) &&
                 (b2[7:4] != 4'hF) &&
                 (b2[3:2] != 2'd3);
    endfunction

    // Same version, layer, sample rate and free-format property
    function automatic logic hdr_match(input logic [15:0] f, input logic [7:0] b1,
                                       input logic [7:0] b2);
        hdr_match = (((f[15:8] ^ b1) & 8'hFE) == 8'h00) &&
                    (((f[7:0] ^ b2) & 8'h0C) == 8'h00) &&
                    ((f[7:4] == 4'h0) == (b2[7:4] == 4'h0));
    endfunction

    // Storage
    logic [7:0]                 prefix_reg [msd_pkg::PREFIX_LEN];
    logic [31:0]                win_reg, win_next;
    logic [15:0]                first_reg, first_next;
    logic                       have_first_reg, have_first_next;
    logic [msd_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    msd_pkg::pos_t              pos_reg, pos_next;
    msd_pkg::skip_t             skip_reg, skip_next;
    logic                       decided_reg, decided_next;
    msd_pkg::tag_t              tag_reg, tag_next;
    logic [msd_pkg::RP_W-1:0]   rp_cnt_reg, rp_cnt_next;
    logic [msd_pkg::RP_W-1:0]   rp_last_reg, rp_last_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_mp3_reg, out_mp3_next;
    msd_pkg::tag_t              out_tag_reg, out_tag_next;

    logic                       id3_ok;
    msd_pkg::tag_t              tag_sum;
    msd_pkg::tag_t              tag_now;
    logic                       pos_is9;
    logic                       chk_en;
    logic [7:0]                 chk_b0, chk_b1, chk_b2;
    msd_pkg::verdict_t          verdict;

    assign pos_is9 = (pos_reg == POS_9);

    // ID3v2 tag length, prefix bytes 0..8 plus the incoming tenth byte
    assign id3_ok = (prefix_reg[0] == 8'h49) && (prefix_reg[1] == 8'h44) &&
                    (prefix_reg[2] == 8'h33) && (prefix_reg[5][3:0] == 4'h0) &&
                    !(prefix_reg[6][7] | prefix_reg[7][7] | prefix_reg[8][7] |
                      data_byte[7]);
    assign tag_sum = {1'b0, prefix_reg[6][6:0], prefix_reg[7][6:0],
                      prefix_reg[8][6:0], data_byte[6:0]} +
                     (prefix_reg[5][4] ? msd_pkg::TAG_W'(2 * msd_pkg::ID3_HDR_LEN)
                                       : msd_pkg::TAG_W'(msd_pkg::ID3_HDR_LEN));
    assign tag_now = id3_ok ? tag_sum : '0;

    // Check unit source: oldest prefix bytes on replay, window otherwise
    assign chk_b0 = cmd.replay_step ? prefix_reg[0] : win_reg[31:24];
    assign chk_b1 = cmd.replay_step ? prefix_reg[1] : win_reg[23:16];
    assign chk_b2 = cmd.replay_step ? prefix_reg[2] : win_reg[15:8];
    assign chk_en = cmd.replay_step ||
                    (cmd.take && (pos_reg >= POS_STRM) && (pos_reg < POS_MAX));

    // Status
    assign stat.decided   = decided_reg;
    assign stat.pos_is9   = pos_is9;
    assign stat.pos_short = (pos_reg >= POS_4) && (pos_reg <= POS_8);
    assign stat.tag_found = (tag_now != '0);
    assign stat.rp_done   = (rp_cnt_reg == rp_last_reg);
    assign stat.out_full  = out_valid_reg;
    assign stat.verdict   = verdict;

    // Header check, per-file bookkeeping and result register
    always_comb
    begin
        win_next        = win_reg;
        first_next      = first_reg;
        have_first_next = have_first_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        skip_next       = skip_reg;
        decided_next    = decided_reg;
        tag_next        = tag_reg;
        rp_cnt_next     = rp_cnt_reg;
        rp_last_next    = rp_last_reg;
        out_valid_next  = out_valid_reg;
        out_mp3_next    = out_mp3_reg;
        out_tag_next    = out_tag_reg;
        verdict         = msd_pkg::VD_NONE;

        if (chk_en)
        begin
            if (skip_reg != '0)
            begin
                skip_next = skip_reg - 1'b1;
            end
            else if (hdr_ok(chk_b0, chk_b1, chk_b2))
            begin
                if (!have_first_reg)
                begin
                    have_first_next = 1'b1;
                    first_next      = {chk_b1, chk_b2};
                    skip_next       = msd_pkg::SKIP_W'(msd_pkg::HDR_SKIP);
                end
                else if (hdr_match(first_reg, chk_b1, chk_b2))
                begin
                    verdict = msd_pkg::VD_YES;
                end
                else if (cnt_reg < msd_pkg::CNT_W'(msd_pkg::COMPARE_LIMIT))
                begin
                    cnt_next  = cnt_reg + 1'b1;
                    skip_next = msd_pkg::SKIP_W'(msd_pkg::HDR_SKIP);
                end
                else
                begin
                    verdict = msd_pkg::VD_NO;
                end
            end
        end

        if (cmd.take)
        begin
            win_next = {win_reg[23:0], data_byte};
            if (pos_reg < POS_MAX)
            begin
                pos_next = pos_reg + 1'b1;
            end
            if (pos_is9)
            begin
                tag_next = tag_now;
                if (tag_now != '0)
                begin
                    skip_next = tag_now - msd_pkg::TAG_W'(msd_pkg::TAG_PRE_OFF);
                end
            end
            rp_cnt_next  = '0;
            rp_last_next = pos_is9 ? msd_pkg::RP_W'(msd_pkg::RP_MAX_OFF)
                                   : pos_reg[msd_pkg::RP_W-1:0] - POS_4[msd_pkg::RP_W-1:0];
        end

        if (cmd.replay_step)
        begin
            rp_cnt_next = rp_cnt_reg + 1'b1;
        end

        if (cmd.set_decided)
        begin
            decided_next = 1'b1;
        end

        if (cmd.clear_file)
        begin
            have_first_next = 1'b0;
            cnt_next        = '0;
            pos_next        = '0;
            skip_next       = '0;
            decided_next    = 1'b0;
            tag_next        = '0;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_mp3_next   = (verdict == msd_pkg::VD_YES);
            out_tag_next   = (cmd.take && pos_is9) ? tag_now : tag_reg;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_first_reg <= 1'b0;
            cnt_reg        <= '0;
            pos_reg        <= '0;
            skip_reg       <= '0;
            decided_reg    <= 1'b0;
            tag_reg        <= '0;
            rp_cnt_reg     <= '0;
            rp_last_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            have_first_reg <= have_first_next;
            cnt_reg        <= cnt_next;
            pos_reg        <= pos_next;
            skip_reg       <= skip_next;
            decided_reg    <= decided_next;
            tag_reg        <= tag_next;
            rp_cnt_reg     <= rp_cnt_next;
            rp_last_reg    <= rp_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        win_reg     <= win_next;
        first_reg   <= first_next;
        out_mp3_reg <= out_mp3_next;
        out_tag_reg <= out_tag_next;
    end

    // Prefix store: written in file order, shifted down one byte per replay step
    always_ff @(posedge clk)
    begin
        if (cmd.take && (pos_reg < POS_PRE))
        begin
            prefix_reg[pos_reg[msd_pkg::PIDX_W-1:0]] <= data_byte;
        end
        else if (cmd.replay_step)
        begin
            for (int k = 0; k < msd_pkg::PREFIX_LEN - 1; k++)
            begin
                prefix_reg[k] <= prefix_reg[k + 1];
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign is_mp3       = out_mp3_reg;
    assign tag_length   = out_tag_reg;

endmodule

// ----- design/mp3_stream_detector_core.sv -----
// Top level of the MPEG audio stream detector.
// Instantiates msd_ctrl and msd_datapath; types from msd_pkg.
//
// Takes a file one byte word per cycle and gives one verdict word per file:
// is_mp3 is 1 once two frame headers agree on version, layer, sample rate and
// free-format, and tag_length gives the bytes of a leading ID3v2 tag (0 if
// none). A verdict comes out when it is reached or at the last byte; the rest
// of a decided file is still accepted at one word per cycle and dropped.
// Bytes flow without a pause, except in two places where the check unit walks
// the stored ten-byte prefix one offset per cycle with input held off: at the
// tenth byte of a file with no ID3v2 tag (offsets 0 to 5 at most) and at the
// last byte of a file of 5 to 9 bytes (offsets 0 to its length minus 5). A
// new word is accepted while the result register is empty or being drained.
module mp3_stream_detector_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    output logic                        byte_ready,
    input  logic [7:0]                  data_byte,
    input  logic                        last_byte,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic                        is_mp3,
    output logic [msd_pkg::TAG_W-1:0]   tag_length
);

    msd_pkg::cmd_t  cmd;
    msd_pkg::stat_t stat;

    msd_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .last_byte    (last_byte),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    msd_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .data_byte    (data_byte),
        .result_ready (result_ready),
        .stat         (stat),
        .result_valid (result_valid),
        .is_mp3       (is_mp3),
        .tag_length   (tag_length)
    );

endmodule

// ----- design/msd_checker.sv -----
// Port-level checks for the MPEG audio stream detector core.
// Bound to mp3_stream_detector_core; uses msd_pkg for widths.
module msd_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_ready,
    input  logic                        result_valid,
    input  logic                        result_ready,
    input  logic                        is_mp3,
    input  logic [msd_pkg::TAG_W-1:0]   tag_length
);

    localparam logic [msd_pkg::TAG_W-1:0] TAG_MIN = msd_pkg::TAG_W'(msd_pkg::ID3_HDR_LEN);
    localparam logic [msd_pkg::TAG_W-1:0] TAG_MAX = msd_pkg::TAG_W'(268435475);

    // A stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(is_mp3) &&
        $stable(tag_length))
        else $error("result word changed while stalled");

    // No new byte while a finished result is blocked
    a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !byte_ready)
        else $error("byte taken while result slot blocked");

    // Tag length is zero or covers at least a full tag header
    a_tag_floor: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (tag_length == '0) || (tag_length >= TAG_MIN))
        else $error("tag length shorter than a tag header");

    // Tag length within syncsafe size plus header and footer
    a_tag_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> tag_length <= TAG_MAX)
        else $error("tag length out of range");

endmodule

bind mp3_stream_detector_core msd_checker u_msd_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_ready   (byte_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .is_mp3       (is_mp3),
    .tag_length   (tag_length)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for mp3_stream_detector_core: streams whole files as byte words
// and checks each verdict word against an in-bench prediction of the detector.
// Depends on msd_pkg and mp3_stream_detector_core only.
module tb_top;

    localparam logic [7:0] SYNC_BYTE   = 8'hFF;
    localparam logic [7:0] ID3_I       = 8'h49;
    localparam logic [7:0] ID3_D       = 8'h44;
    localparam logic [7:0] ID3_3       = 8'h33;
    localparam int         HDR_BYTES   = 4;
    localparam int         STALL_LIMIT = 2000;
    localparam int         DRAIN_GAP   = 16;
    localparam int         END_GAP     = 20;
    localparam int         MAX_SHOWN   = 10;

    typedef enum logic [1:0] {
        PH_TX_HEAVY,
        PH_RX_HEAVY,
        PH_NO_IDLE
    } idle_phase_t;

    typedef enum logic [1:0] {
        FR_FRESH,
        FR_MATCH,
        FR_DIFF
    } frame_kind_t;

    typedef struct packed {
        logic           mp3;
        msd_pkg::tag_t  tag;
    } verdict_word_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        eof;
        logic        drain;    // marker: hold off until all verdicts are in
        idle_phase_t phase;
    } byte_word_t;

    logic          clk          = 1'b0;
    logic          rst_n        = 1'b0;
    logic          byte_valid   = 1'b0;
    logic          byte_ready;
    logic [7:0]    data_byte    = 8'h00;
    logic          last_byte    = 1'b0;
    logic          result_valid;
    logic          result_ready = 1'b0;
    logic          is_mp3;
    msd_pkg::tag_t tag_length;

    byte_word_t    byte_q[$];
    verdict_word_t verdict_q[$];
    idle_phase_t   gen_phase = PH_TX_HEAVY;
    idle_phase_t   cur_phase = PH_TX_HEAVY;

    int unsigned n_queued    = 0;
    int unsigned n_files     = 0;
    int unsigned n_bytes_in  = 0;
    int unsigned n_verdicts  = 0;
    int unsigned n_yes       = 0;
    int unsigned n_fail      = 0;
    int unsigned hold_left   = 0;
    int unsigned stall_count = 0;
    bit          run_over    = 1'b0;

    // Detector state as tracked by the predictor
    logic [7:0]                pfx [msd_pkg::PREFIX_LEN] = '{default: '0};
    logic [39:0]               win       = '0;
    logic [15:0]               hdr1      = '0;
    logic                      hdr1_seen = 1'b0;
    logic [msd_pkg::CNT_W-1:0] n_mism    = '0;
    msd_pkg::pos_t             nbytes    = '0;
    msd_pkg::skip_t            skip_left = '0;
    logic                      file_done = 1'b0;

    mp3_stream_detector_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .is_mp3       (is_mp3),
        .tag_length   (tag_length)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------
    function automatic void start_file();
        win       = '0;
        hdr1      = '0;
        hdr1_seen = 1'b0;
        n_mism    = '0;
        nbytes    = '0;
        skip_left = '0;
        file_done = 1'b0;
    endfunction

    // Bytes covered by a leading ID3v2 tag, 0 when the prefix is not one
    function automatic msd_pkg::tag_t id3_span();
        msd_pkg::tag_t t;
        if (pfx[0] != ID3_I || pfx[1] != ID3_D || pfx[2] != ID3_3)
            return '0;
        if (pfx[5][3:0] != 4'h0 || (pfx[6][7] | pfx[7][7] | pfx[8][7] | pfx[9][7]))
            return '0;
        t = {1'b0, pfx[6][6:0], pfx[7][6:0], pfx[8][6:0], pfx[9][6:0]};
        t = t + msd_pkg::tag_t'(msd_pkg::ID3_HDR_LEN);
        if (pfx[5][4])
            t = t + msd_pkg::tag_t'(msd_pkg::ID3_HDR_LEN);
        return t;
    endfunction

    function automatic logic frame_ok(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
        return b0 == SYNC_BYTE
            && (b1[7:4] == 4'hF || b1[7:1] == 7'h71)
            && b1[2:1] != 2'b00
            && b2[7:4] != 4'hF
            && b2[3:2] != 2'b11;
    endfunction

    // Header check at one offset; updates the per-file scan state
    function automatic msd_pkg::verdict_t probe(int unsigned off, logic [7:0] b0,
                                                logic [7:0] b1, logic [7:0] b2);
        if (off >= msd_pkg::SCAN_LIMIT)
            return msd_pkg::VD_NONE;
        if (skip_left != 0)
        begin
            skip_left = skip_left - 1'b1;
            return msd_pkg::VD_NONE;
        end
        if (!frame_ok(b0, b1, b2))
            return msd_pkg::VD_NONE;
        if (!hdr1_seen)
        begin
            hdr1_seen = 1'b1;
            hdr1      = {b1, b2};
            skip_left = msd_pkg::skip_t'(msd_pkg::HDR_SKIP);
            return msd_pkg::VD_NONE;
        end
        if (hdr1[15:9] == b1[7:1] && hdr1[3:2] == b2[3:2]
            && ((hdr1[7:4] == 4'h0) == (b2[7:4] == 4'h0)))
            return msd_pkg::VD_YES;
        if (n_mism < msd_pkg::COMPARE_LIMIT)
        begin
            n_mism    = n_mism + 1'b1;
            skip_left = msd_pkg::skip_t'(msd_pkg::HDR_SKIP);
            return msd_pkg::VD_NONE;
        end
        return msd_pkg::VD_NO;
    endfunction

    function automatic msd_pkg::verdict_t replay_prefix(int unsigned last_off);
        msd_pkg::verdict_t v = msd_pkg::VD_NONE;
        for (int c = 0; c <= last_off && c <= msd_pkg::RP_MAX_OFF && v == msd_pkg::VD_NONE;
             c++)
            v = probe(c, pfx[c], pfx[c + 1], pfx[c + 2]);
        return v;
    endfunction

    // Next detector state for one byte; has_res flags a verdict word
    function automatic void scan_byte(input logic [7:0] b, input logic eof,
                                      output logic has_res, output verdict_word_t res);
        int unsigned       p;
        msd_pkg::tag_t     t;
        msd_pkg::verdict_t v;
        has_res = 1'b0;
        res     = '0;
        v       = msd_pkg::VD_NONE;
        p       = nbytes;
        if (file_done)
        begin
            if (eof)
                start_file();
            return;
        end
        if (p < msd_pkg::PREFIX_LEN)
            pfx[p] = b;
        win = {win[31:0], b};

        if (p == msd_pkg::PREFIX_LEN - 1)
        begin
            t = id3_span();
            if (t != 0)
                skip_left = msd_pkg::skip_t'(t - msd_pkg::TAG_PRE_OFF);
            else
                v = replay_prefix(msd_pkg::RP_MAX_OFF);
        end
        else if (p >= msd_pkg::STREAM_START)
            v = probe(p - HDR_BYTES, win[39:32], win[31:24], win[23:16]);
        else if (eof && p >= HDR_BYTES)
            v = replay_prefix(p - HDR_BYTES);

        if (p < msd_pkg::POS_CAP)
            nbytes = nbytes + 1'b1;

        if (v != msd_pkg::VD_NONE || eof)
        begin
            has_res = 1'b1;
            res.mp3 = (v == msd_pkg::VD_YES);
            res.tag = (p >= msd_pkg::PREFIX_LEN - 1) ? id3_span() : '0;
            if (eof)
                start_file();
            else
                file_done = 1'b1;
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic int idle_pct(idle_phase_t ph, logic rx_side);
        case (ph)
            PH_TX_HEAVY: return rx_side ? 48 : 31;
            PH_RX_HEAVY: return rx_side ? 31 : 48;
            default:     return 0;
        endcase
    endfunction

    function automatic logic [7:0] any_byte(logic no_sync);
        return no_sync ? 8'($urandom_range(254)) : 8'($urandom_range(255));
    endfunction

    // Appends a valid frame header; returns byte 1 and byte 2 with its low two bits cleared
    function automatic logic [15:0] add_frame(ref logic [7:0] f[$], input logic [15:0] ref_hdr,
                                              input frame_kind_t kind);
        logic [7:0] b1;
        logic [3:0] rate;
        logic [1:0] sr;
        logic       ff_ref;
        int         pick;
        ff_ref = (ref_hdr[7:4] == 4'h0);
        if (kind == FR_FRESH)
        begin
            if ($urandom_range(1))
                b1 = {4'hF, 1'($urandom_range(1)), 2'($urandom_range(3, 1)),
                      1'($urandom_range(1))};
            else
                b1 = {7'h71, 1'($urandom_range(1))};
            rate = ($urandom_range(3) == 0) ? 4'h0 : 4'($urandom_range(14));
            sr   = 2'($urandom_range(2));
        end
        else
        begin
            b1   = {ref_hdr[15:9], 1'($urandom_range(1))};
            rate = ff_ref ? 4'h0 : 4'($urandom_range(14, 1));
            sr   = ref_hdr[3:2];
            // disagree on exactly one of sample rate, free-format, version/layer
            if (kind == FR_DIFF)
            begin
                pick = $urandom_range(2);
                if (pick == 0)
                    sr = 2'((ref_hdr[3:2] + $urandom_range(2, 1)) % 3);
                else if (pick == 1)
                    rate = ff_ref ? 4'($urandom_range(14, 1)) : 4'h0;
                else if (b1[7:4] == 4'hF)
                    b1[3] = ~b1[3];
                else
                    b1 = {4'hF, 1'b1, 2'b01, b1[0]};
            end
        end
        f.push_back(SYNC_BYTE);
        f.push_back(b1);
        f.push_back({rate, sr, 2'($urandom_range(3))});
        f.push_back(any_byte(1'b0));
        return {b1, rate, sr, 2'b00};
    endfunction

    task automatic push_file(input logic [7:0] f[$]);
        foreach (f[i])
            byte_q.push_back('{data: f[i], eof: (i == f.size() - 1), drain: 1'b0,
                               phase: gen_phase});
        n_queued += f.size();
        n_files++;
    endtask

    task automatic push_drain();
        byte_q.push_back('{data: 8'h00, eof: 1'b0, drain: 1'b1, phase: gen_phase});
    endtask

    // One random file: a stream with headers, plain noise, or a short file
    task automatic queue_random_file();
        logic [7:0]  f[$];
        logic [7:0]  flags;
        logic [7:0]  sz[4];
        logic [15:0] h;
        int          pick;
        int          sub;
        int          body;
        int          nmis;
        int          len;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            sub = $urandom_range(99);
            if (sub < 40)
            begin
                flags = {3'($urandom_range(7)), 1'($urandom_range(1)), 4'h0};
                sz    = '{8'h00, 8'h00, 8'h00, 8'($urandom_range(24))};
                body  = 0;
                if (sub < 25)
                    body = sz[3] + (flags[4] ? msd_pkg::ID3_HDR_LEN : 0);
                else if (sub < 35)
                begin
                    // malformed tag: flag nibble set or a size byte with bit 7
                    if ($urandom_range(1))
                        flags[3:0] = 4'($urandom_range(15, 1));
                    else
                        sz[$urandom_range(3)][7] = 1'b1;
                end
                else
                begin
                    // tag far longer than the file
                    foreach (sz[k])
                        sz[k] = 8'($urandom_range(127));
                end
                f = {ID3_I, ID3_D, ID3_3, any_byte(1'b0), any_byte(1'b0), flags,
                     sz[0], sz[1], sz[2], sz[3]};
                repeat (body)
                    f.push_back(any_byte(1'b0));
            end
            repeat ($urandom_range(6))
                f.push_back(any_byte(1'b1));
            h    = add_frame(f, 16'h0000, FR_FRESH);
            nmis = ($urandom_range(2) == 0) ? $urandom_range(12, 9) : $urandom_range(2);
            repeat (nmis)
            begin
                repeat ($urandom_range(3))
                    f.push_back(any_byte(1'b1));
                void'(add_frame(f, h, FR_DIFF));
            end
            if ($urandom_range(9) < 7)
            begin
                repeat ($urandom_range(3))
                    f.push_back(any_byte(1'b1));
                void'(add_frame(f, h, FR_MATCH));
            end
            repeat ($urandom_range(4, 1))
                f.push_back(any_byte(1'b0));
        end
        else if (pick < 75)
        begin
            repeat ($urandom_range(24, 1))
                f.push_back(($urandom_range(3) == 0) ? SYNC_BYTE : any_byte(1'b0));
        end
        else
        begin
            len = ($urandom_range(9) < 3) ? 9 : $urandom_range(9, 1);
            if ($urandom_range(1))
            begin
                repeat ($urandom_range(2))
                    f.push_back(any_byte(1'b1));
                h = add_frame(f, 16'h0000, FR_FRESH);
                if ($urandom_range(1))
                    void'(add_frame(f, h, $urandom_range(1) ? FR_MATCH : FR_DIFF));
            end
            while (f.size() < len)
                f.push_back(any_byte(1'b0));
            while (f.size() > len)
                void'(f.pop_back());
        end
        push_file(f);
    endtask

    task automatic note_failure(input string what);
        n_fail++;
        if (n_fail <= MAX_SHOWN)
            $display("ERROR at %0t: %s", $time, what);
    endtask

    // ---------------------------------------------------------------
    // Byte word driver; predicts on every accepted word
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : byte_driver
        logic          show;
        logic          got;
        verdict_word_t v;
        byte_word_t    w;
        show = byte_valid;
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
            begin
                scan_byte(data_byte, last_byte, got, v);
                if (got)
                    verdict_q.push_back(v);
                n_bytes_in++;
                show = 1'b0;
            end
            if (!show)
            begin
                if (hold_left != 0)
                    hold_left--;
                else if (byte_q.size() != 0)
                begin
                    w = byte_q[0];
                    if (w.drain)
                    begin
                        if (verdict_q.size() == 0)
                        begin
                            void'(byte_q.pop_front());
                            hold_left = DRAIN_GAP;
                        end
                    end
                    else if ($urandom_range(99) >= idle_pct(w.phase, 1'b0))
                    begin
                        void'(byte_q.pop_front());
                        cur_phase = w.phase;
                        show      = 1'b1;
                        data_byte <= w.data;
                        last_byte <= w.eof;
                    end
                end
            end
            byte_valid <= show;
        end
    end

    // ---------------------------------------------------------------
    // Verdict monitor and checker
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : verdict_monitor
        verdict_word_t e;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                n_verdicts++;
                if (is_mp3)
                    n_yes++;
                if (verdict_q.size() == 0)
                    note_failure($sformatf("unexpected verdict is_mp3=%0b tag_length=%0d",
                                           is_mp3, tag_length));
                else
                begin
                    e = verdict_q.pop_front();
                    if (is_mp3 !== e.mp3 || tag_length !== e.tag)
                        note_failure($sformatf(
                            {"verdict %0d: expected is_mp3=%0b tag_length=%0d,",
                             " got is_mp3=%0b tag_length=%0d"},
                            n_verdicts, e.mp3, e.tag, is_mp3, tag_length));
                end
            end
            result_ready <= ($urandom_range(99) >= idle_pct(cur_phase, 1'b1));
        end
    end

    // Watchdog: ends the run if no word moves for too long
    always @(posedge clk)
    begin
        if (rst_n && !run_over)
        begin
            if ((byte_valid && byte_ready) || (result_valid && result_ready))
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("Watchdog: no word moved for %0d cycles, %0d verdicts outstanding",
                         stall_count, verdict_q.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin
        logic [7:0]  f[$];

        // two agreeing headers in a 9-byte file
        f = {SYNC_BYTE, 8'hF3, 8'h44, 8'h00, SYNC_BYTE, 8'hF2, 8'h46, 8'h11, 8'h00};
        push_file(f);
        // too short to hold a checkable header
        f = {SYNC_BYTE, 8'hFB, 8'h90, 8'h00};
        push_file(f);
        f = {SYNC_BYTE};
        push_file(f);
        // largest tag with footer, far past the scan limit
        f = {ID3_I, ID3_D, ID3_3, 8'h04, 8'h00, 8'hF0, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h00};
        push_file(f);

        while (n_queued < 260)
            queue_random_file();
        push_drain();
        gen_phase = PH_RX_HEAVY;
        while (n_queued < 520)
            queue_random_file();
        push_drain();
        gen_phase = PH_NO_IDLE;
        while (n_queued < 780)
            queue_random_file();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_q.size() != 0 || byte_valid)
            @(negedge clk);
        while (verdict_q.size() != 0)
            @(negedge clk);
        repeat (END_GAP) @(negedge clk);
        run_over = 1'b1;

        $display("Streamed %0d files (%0d bytes: tags, headers, noise, short files)",
                 n_files, n_bytes_in);
        $display("under three idle mixes; checked %0d verdict words, %0d of them MPEG, %0d failures.",
                 n_verdicts, n_yes, n_fail);
        if (n_fail == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
